// ----- rtl/lzw_pkg.sv -----
// ----------------------------------------------------------------------------
// lzw_pkg
// Shared widths, types and the slot hash for the LZW compressor.
// ----------------------------------------------------------------------------
package lzw_pkg;

	// dictionary geometry
	localparam int DICT_ENTRIES = 4096;
	localparam int CODE_W       = $clog2(DICT_ENTRIES);
	localparam int NF_W         = CODE_W + 1;
	localparam int SLOT_W       = CODE_W + 1;
	localparam int SLOT_ENTRIES = 2 * DICT_ENTRIES;
	localparam int FIRST_FREE   = 256;

	// stream field widths
	localparam int BYTE_W       = 8;
	localparam int OUT_CODE_W   = 12;
	localparam int OUT_TDATA_W  = 16;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [NF_W-1:0]   nf_t;
	typedef logic [BYTE_W-1:0] byte_t;

	// one dictionary entry: string prefix, appended byte, hash slot holding it
	typedef struct packed {
		code_t prefix;
		byte_t data_byte;
		slot_t slot;
	} dict_entry_t;

	// hash slot memory access
	typedef struct packed {
		logic  rd_en;
		slot_t rd_addr;
		logic  wr_en;
		slot_t wr_addr;
		code_t wr_data;
	} slot_req_t;

	// dictionary memory access
	typedef struct packed {
		logic        rd_en;
		code_t       rd_addr;
		logic        wr_en;
		code_t       wr_addr;
		dict_entry_t wr_data;
	} dict_req_t;

	// one result word
	typedef struct packed {
		logic                  last;
		logic [OUT_CODE_W-1:0] code;
	} out_word_t;

	typedef struct packed {
		logic      valid;
		out_word_t word;
	} out_push_t;

	// home slot of a (prefix, byte) key
	function automatic slot_t hash_slot(code_t prefix, byte_t b);
		return slot_t'({prefix, 1'b0}) ^ slot_t'({b, {(SLOT_W-BYTE_W){1'b0}}}) ^ slot_t'(b);
	endfunction

endpackage

// ----- rtl/lzw_compressor_top.sv -----
// ----------------------------------------------------------------------------
// lzw_compressor_top
// Byte-in, code-out LZW compressor with a hashed dictionary.
// A byte is looked up in the look and compare states, repeated for each extra
// slot probe (linear probing); the first byte of a message skips the probe,
// and a full output queue can stall the compare and finish states.
// A code is pushed into the output queue when a probe rules its key out, and
// the final code of a message is pushed from the finish state.
// Reset clears the sequencer and the queue, then zeroes every slot of the slot
// table with the input not ready; the dictionary needs no clearing.
// ----------------------------------------------------------------------------
module lzw_compressor_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // code[11:0], zero pad
	output logic        m_axis_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_CMP  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]            state_q;
	lzw_pkg::code_t        cur_q;
	logic                  active_q;
	lzw_pkg::nf_t          next_free_q;
	lzw_pkg::byte_t        byte_q;
	logic                  eom_q;
	lzw_pkg::slot_t        slot_q;
	lzw_pkg::code_t        cand_q;
	logic                  in_range_q;
	logic                  clr_busy_q;
	lzw_pkg::slot_t        clr_addr_q;

	lzw_pkg::slot_req_t    slot_req;
	lzw_pkg::code_t        slot_rd_data;
	lzw_pkg::dict_req_t    dict_req;
	lzw_pkg::dict_entry_t  entry;
	lzw_pkg::out_push_t    push;
	logic                  fifo_full;

	logic                  s_accept;
	logic                  entry_valid;
	logic                  entry_match;
	logic                  dict_room;
	logic                  probe_start;
	logic                  probe_next;
	logic                  miss_take;
	logic                  flush_take;
	logic                  add_entry;
	lzw_pkg::slot_t        slot_inc;
	lzw_pkg::slot_t        home_slot;

	assign s_axis_tready = (state_q == ST_IDLE) && !clr_busy_q;
	assign s_accept      = s_axis_tvalid & s_axis_tready;

	// shared compare unit: slot owns the entry, entry holds the key
	assign entry_valid = in_range_q && (entry.slot == slot_q);
	assign entry_match = entry_valid && (entry.prefix == cur_q) && (entry.data_byte == byte_q);
	assign dict_room   = (next_free_q < lzw_pkg::NF_W'(lzw_pkg::DICT_ENTRIES));

	assign slot_inc  = slot_q + lzw_pkg::SLOT_W'(1);
	assign home_slot = lzw_pkg::hash_slot(cur_q, s_axis_tdata);

	// sequencer events
	assign probe_start = s_accept && active_q;
	assign probe_next  = (state_q == ST_CMP) && entry_valid && !entry_match;
	assign miss_take   = (state_q == ST_CMP) && !entry_valid && !fifo_full;
	assign flush_take  = (state_q == ST_FIN) && eom_q && !fifo_full;
	assign add_entry   = miss_take && dict_room;

	// memory requests and result push
	always_comb begin
		slot_req.rd_en   = probe_start | probe_next;
		slot_req.rd_addr = probe_start ? home_slot : slot_inc;
		slot_req.wr_en   = add_entry | clr_busy_q;
		slot_req.wr_addr = clr_busy_q ? clr_addr_q : slot_q;
		slot_req.wr_data = clr_busy_q ? '0 : next_free_q[lzw_pkg::CODE_W-1:0];

		dict_req.rd_en                   = (state_q == ST_LOOK);
		dict_req.rd_addr                 = slot_rd_data;
		dict_req.wr_en                   = add_entry;
		dict_req.wr_addr                 = next_free_q[lzw_pkg::CODE_W-1:0];
		dict_req.wr_data.prefix          = cur_q;
		dict_req.wr_data.data_byte       = byte_q;
		dict_req.wr_data.slot            = slot_q;

		push.valid     = miss_take | flush_take;
		push.word.last = flush_take;
		push.word.code = lzw_pkg::OUT_CODE_W'(cur_q);
	end

	// slot table clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + lzw_pkg::SLOT_W'(1);
			if (clr_addr_q == lzw_pkg::SLOT_W'(lzw_pkg::SLOT_ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// sequencer and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			active_q    <= 1'b0;
			next_free_q <= lzw_pkg::NF_W'(lzw_pkg::FIRST_FREE);
			byte_q      <= '0;
			eom_q       <= 1'b0;
			slot_q      <= '0;
			cand_q      <= '0;
			in_range_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						byte_q <= s_axis_tdata;
						eom_q  <= s_axis_tlast;
						if (active_q) begin
							slot_q  <= home_slot;
							state_q <= ST_LOOK;
						end else begin
							cur_q    <= lzw_pkg::CODE_W'(s_axis_tdata);
							active_q <= 1'b1;
							state_q  <= ST_FIN;
						end
					end
				end
				ST_LOOK: begin
					cand_q     <= slot_rd_data;
					in_range_q <= (slot_rd_data >= lzw_pkg::CODE_W'(lzw_pkg::FIRST_FREE)) &&
						(lzw_pkg::NF_W'(slot_rd_data) < next_free_q);
					state_q    <= ST_CMP;
				end
				ST_CMP: begin
					if (entry_match) begin
						cur_q   <= cand_q;
						state_q <= ST_FIN;
					end else if (entry_valid) begin
						slot_q  <= slot_inc;
						state_q <= ST_LOOK;
					end else if (!fifo_full) begin
						if (dict_room) begin
							next_free_q <= next_free_q + lzw_pkg::NF_W'(1);
						end
						cur_q   <= lzw_pkg::CODE_W'(byte_q);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!eom_q) begin
						state_q <= ST_IDLE;
					end else if (!fifo_full) begin
						cur_q       <= '0;
						active_q    <= 1'b0;
						next_free_q <= lzw_pkg::NF_W'(lzw_pkg::FIRST_FREE);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	lzw_slot_ram u_slot_ram (
		.clk     (clk),
		.req     (slot_req),
		.rd_data (slot_rd_data)
	);

	lzw_dict_ram u_dict_ram (
		.clk     (clk),
		.req     (dict_req),
		.rd_data (entry)
	);

	lzw_out_fifo u_out_fifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (fifo_full),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// free code pointer stays between the first free code and the table size
	a_next_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		(next_free_q >= lzw_pkg::NF_W'(lzw_pkg::FIRST_FREE)) &&
		(next_free_q <= lzw_pkg::NF_W'(lzw_pkg::DICT_ENTRIES)))
		else $error("next free code out of range");

	// first byte of a message starts the string without a probe
	a_first_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && !active_q) |=> (state_q == ST_FIN && active_q))
		else $error("first byte did not start a string");

	// each new entry takes exactly the next free code
	a_add_advances: assert property (@(posedge clk) disable iff (!arst_n)
		add_entry |=> (next_free_q == $past(next_free_q) + lzw_pkg::NF_W'(1)))
		else $error("dictionary add did not advance free code");

	// end of message flush returns to an empty dictionary
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		flush_take |=> (!active_q && state_q == ST_IDLE &&
		next_free_q == lzw_pkg::NF_W'(lzw_pkg::FIRST_FREE)))
		else $error("flush did not clear dictionary state");

endmodule

// ----- rtl/lzw_slot_ram.sv -----
// ----------------------------------------------------------------------------
// lzw_slot_ram
// Hash slot table: each slot holds the code last placed there.
// ----------------------------------------------------------------------------
module lzw_slot_ram (
	input  logic              clk,
	input  lzw_pkg::slot_req_t req,
	output lzw_pkg::code_t    rd_data
);

	lzw_pkg::code_t slot_mem_q [lzw_pkg::SLOT_ENTRIES];
	lzw_pkg::code_t rd_data_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			slot_mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= slot_mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/lzw_dict_ram.sv -----
// ----------------------------------------------------------------------------
// lzw_dict_ram
// Dictionary store indexed by code: prefix, appended byte and owning slot.
// ----------------------------------------------------------------------------
module lzw_dict_ram (
	input  logic                  clk,
	input  lzw_pkg::dict_req_t    req,
	output lzw_pkg::dict_entry_t  rd_data
);

	lzw_pkg::dict_entry_t dict_mem_q [lzw_pkg::DICT_ENTRIES];
	lzw_pkg::dict_entry_t rd_data_q;

	// one write port, one registered read port; read data holds when idle
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			dict_mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= dict_mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/lzw_out_fifo.sv -----
// ----------------------------------------------------------------------------
// lzw_out_fifo
// Two-word result queue in front of the output stream.
// ----------------------------------------------------------------------------
module lzw_out_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  lzw_pkg::out_push_t push,
	output logic               full,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [lzw_pkg::OUT_TDATA_W-1:0] m_axis_tdata, // code[11:0], zero pad
	output logic               m_axis_tlast
);

	lzw_pkg::out_word_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               pop;
	lzw_pkg::out_word_t head;

	assign pop  = m_axis_tvalid & m_axis_tready;
	assign full = (count_q == 2'd2);
	assign head = entry_q[rd_ptr_q];

	// word storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.word;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push.valid) - 2'(pop);
		end
	end

	assign m_axis_tvalid = (count_q != 2'd0);
	assign m_axis_tdata  = {{(lzw_pkg::OUT_TDATA_W-lzw_pkg::OUT_CODE_W){1'b0}}, head.code};
	assign m_axis_tlast  = head.last;

	// queue never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'd2)
		else $error("result queue count out of range");

	// producer only pushes into free space
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("push into full result queue");

endmodule

// ----- dv/lzw_code_checker.sv -----
// ----------------------------------------------------------------------------
// lzw_code_checker
// Watches both streams of the LZW compressor. Every accepted input word runs
// through a local string table that tracks the codes the block must emit, and
// every accepted output word is compared with the oldest code still owed.
// ----------------------------------------------------------------------------
module lzw_code_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,  // code[11:0], zero pad
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          pending
);

	// string table: key {prefix code, appended byte} -> code
	lzw_pkg::code_t     string_table [bit [19:0]];
	lzw_pkg::nf_t       next_free;
	lzw_pkg::code_t     current_code;
	logic               string_active;
	lzw_pkg::out_word_t owed_codes [$];
	lzw_pkg::out_word_t head_word;
	int                 errors;

	// advance the string table by one byte and queue the codes it emits
	function automatic void predict_codes(lzw_pkg::byte_t b, logic eom);
		bit [19:0] key;
		key = {current_code, b};
		if (!string_active) begin
			current_code  = lzw_pkg::code_t'(b);
			string_active = 1'b1;
		end else if (string_table.exists(key)) begin
			current_code = string_table[key];
		end else begin
			owed_codes.push_back('{last: 1'b0,
				code: lzw_pkg::OUT_CODE_W'(current_code)});
			// a full table stops growing but keeps emitting
			if (next_free < lzw_pkg::DICT_ENTRIES) begin
				string_table[key] = lzw_pkg::code_t'(next_free);
				next_free++;
			end
			current_code = lzw_pkg::code_t'(b);
		end
		// end of message: flush and start over with the single-byte codes
		if (eom) begin
			owed_codes.push_back('{last: 1'b1,
				code: lzw_pkg::OUT_CODE_W'(current_code)});
			current_code  = '0;
			string_active = 1'b0;
			next_free     = lzw_pkg::nf_t'(lzw_pkg::FIRST_FREE);
			string_table.delete();
		end
	endfunction

	// track accepted words on both sides
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_table.delete();
			owed_codes.delete();
			next_free     = lzw_pkg::nf_t'(lzw_pkg::FIRST_FREE);
			current_code  = '0;
			string_active = 1'b0;
			errors        = 0;
			fail_count    <= 0;
			pending       <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_codes(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_codes.size() == 0) begin
					$error("unexpected code word: code %0d last %0b",
						m_axis_tdata[11:0], m_axis_tlast);
					errors++;
				end else begin
					head_word = owed_codes.pop_front();
					if (m_axis_tdata[11:0] !== head_word.code) begin
						$error("code: expected %0d, actual %0d",
							head_word.code, m_axis_tdata[11:0]);
						errors++;
					end
					if (m_axis_tlast !== head_word.last) begin
						$error("last_code: expected %0b, actual %0b",
							head_word.last, m_axis_tlast);
						errors++;
					end
					if (m_axis_tdata[15:12] !== 4'h0) begin
						$error("pad: expected %0h, actual %0h", 4'h0, m_axis_tdata[15:12]);
						errors++;
					end
				end
			end
			fail_count <= errors;
			pending    <= owed_codes.size();
		end
	end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives messages into the LZW compressor: a few directed messages for the
// single-byte, mismatch-at-end and repeat cases, one long message that grows
// the dictionary, then random messages over small alphabets with noise.
// Both sides stall at random; the checker beside the block scores the codes.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TOTAL_WORDS = 1600;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;  // data_byte[7:0]
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // code[11:0], zero pad
	logic        m_axis_tlast;

	int   fail_count;
	int   pending;
	int   cycles     = 0;
	int   words_sent = 0;
	logic no_idle    = 1'b0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	lzw_compressor_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	lzw_code_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 14);
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** lzw_compressor_top: FAILED **");
			$finish;
		end
	end

	// offer one word, with random idle cycles ahead of it
	task automatic send_word(input lzw_pkg::byte_t b, input logic eom);
		while (!no_idle && $urandom_range(0, 99) < 14) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eom;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
	endtask

	// message over a small random alphabet with a share of full-range noise
	task automatic send_message(input int len, input int alpha_n, input int noise_pct);
		lzw_pkg::byte_t alphabet [4];
		lzw_pkg::byte_t b;
		for (int i = 0; i < 4; i++)
			alphabet[i] = lzw_pkg::byte_t'($urandom);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				b = lzw_pkg::byte_t'($urandom);
			else
				b = alphabet[$urandom_range(0, alpha_n - 1)];
			send_word(b, i == len - 1);
		end
	endtask

	// stimulus and verdict
	initial begin
		int len;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte messages at both extremes
		send_word(8'h00, 1'b1);
		send_word(8'hff, 1'b1);
		// mismatch on the final byte, twice to see the table cleared
		send_word(8'h41, 1'b0);
		send_word(8'h42, 1'b1);
		send_word(8'h41, 1'b0);
		send_word(8'h42, 1'b1);
		// a run of one byte: growing hits, final byte a miss
		repeat (6) send_word(8'h55, 1'b0);
		send_word(8'h55, 1'b1);
		// alternating extremes
		for (int i = 0; i < 7; i++)
			send_word(i[0] ? 8'h00 : 8'hff, i == 6);

		// one long message that grows the dictionary, then repeats into it
		for (int i = 0; i < 500; i++)
			send_word(lzw_pkg::byte_t'($urandom), 1'b0);
		send_message(200, 3, 10);
		send_message(20, 2, 0);

		// random messages, with a quiet stretch in the middle
		while (words_sent < TOTAL_WORDS) begin
			no_idle <= (words_sent > 1000 && words_sent < 1300);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300)
			                                  : $urandom_range(1, 30);
			if ($urandom_range(0, 7) == 0)
				send_message(len, 4, 100);
			else
				send_message(len, $urandom_range(1, 4), $urandom_range(0, 20));
		end
		s_axis_tvalid <= 1'b0;
		no_idle       <= 1'b0;

		// drain
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("** lzw_compressor_top: PASSED **");
		else
			$display("** lzw_compressor_top: FAILED **");
		$finish;
	end

endmodule
